>>> hw/rtl/api_frame_receive_router_unit_macros.svh
// Assertion macros shared by the frame receive router RTL.
`ifndef API_FRAME_RECEIVE_ROUTER_UNIT_MACROS_SVH
`define API_FRAME_RECEIVE_ROUTER_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define AFRR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clk edge outside reset.
`define AFRR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/afrr_pkg.sv
// Package with the constants and types of the frame receive router.
`timescale 1ns / 1ps

package afrr_pkg;

	localparam int POS_W = 17;

	localparam logic [7:0] START_BYTE     = 8'h7E;
	localparam logic [7:0] KIND_AT_RESP   = 8'h88;
	localparam logic [7:0] KIND_MODEM     = 8'h8A;
	localparam logic [7:0] KIND_RX_PACKET = 8'h90;

	// Positions counted with the start byte at zero, as seen after the
	// position counter has advanced for the current byte (one ahead).
	localparam logic [POS_W-1:0] POS_LEN_HI    = 17'd2;
	localparam logic [POS_W-1:0] POS_LEN_LO    = 17'd3;
	localparam logic [POS_W-1:0] POS_KIND      = 17'd4;
	localparam logic [POS_W-1:0] POS_MODEM     = 17'd5;
	localparam logic [POS_W-1:0] POS_AT_STATUS = 17'd8;
	localparam logic [POS_W-1:0] POS_PAYLOAD   = 17'd16;
	localparam logic [POS_W-1:0] DATA_OFFSET   = 17'd4;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_JOIN_OPEN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_JOIN_CLOSED = 2'd2;

	localparam logic [7:0] JOIN_OPEN_RESET   = 8'd67;
	localparam logic [7:0] JOIN_CLOSED_RESET = 8'd68;

	typedef struct packed {
		logic       enable;
		logic [7:0] join_open_code;
		logic [7:0] join_closed_code;
	} cfg_t;

	typedef struct packed {
		logic       at_byte_valid;
		logic       payload_valid;
		logic [7:0] byte_value;
		logic       status_valid;
		logic [7:0] modem_code;
		logic       at_done;
		logic [7:0] at_result;
		logic       frame_end;
	} result_t;

endpackage

>>> hw/rtl/api_frame_receive_router_unit.sv
// Top level of the frame receive router: config registers, parser, output buffer.
// A byte's result is decoded combinationally and registered in the output buffer before
// it appears on m_tvalid. Throughput: one byte per cycle while s_tready is high.
// The two-entry output buffer keeps s_tready high through a single stalled result.
// Reset (arst_n low, asynchronous) returns the parser to hunting, clears length,
// kind and AT status, empties the buffer, and loads the register reset values.
`timescale 1ns / 1ps

module api_frame_receive_router_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	// Received byte stream.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,    // [7:0] rx_byte
	// Routed result stream, one beat per received byte.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [23:0]                     m_tdata,    // [7:0] byte_value, [15:8] modem_code,
	                                                    // [23:16] at_result
	output logic [3:0]                      m_tuser,    // [0] at_byte_valid, [1] payload_valid,
	                                                    // [2] status_valid, [3] at_done
	output logic                            m_tlast,    // frame_end
	// Configuration writes.
	input  logic                            cfg_wr_en,
	input  logic [afrr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [afrr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import afrr_pkg::*;

	cfg_t    cfg_q;
	result_t parse_res, buf_res;
	logic    in_accept;

	// Configuration registers. Writes to an index past the last register
	// are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable           <= 1'b0;
			cfg_q.join_open_code   <= JOIN_OPEN_RESET;
			cfg_q.join_closed_code <= JOIN_CLOSED_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ENABLE:      cfg_q.enable           <= cfg_data[0];
				REG_JOIN_OPEN:   cfg_q.join_open_code   <= cfg_data;
				REG_JOIN_CLOSED: cfg_q.join_closed_code <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Every accepted byte yields exactly one result beat, even a dropped or
	// ignored byte (all fields zero then), so the buffer's ready gates input.
	assign in_accept = s_tvalid && s_tready;

	afrr_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_accept (in_accept),
		.in_byte   (s_tdata),
		.res       (parse_res)
	);

	afrr_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (parse_res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (buf_res)
	);

	assign m_tdata = {buf_res.at_result, buf_res.modem_code, buf_res.byte_value};
	assign m_tuser = {buf_res.at_done, buf_res.status_valid,
	                  buf_res.payload_valid, buf_res.at_byte_valid};
	assign m_tlast = buf_res.frame_end;

endmodule

>>> hw/rtl/afrr_parser.sv
// Frame position tracking and per-byte routing decode.
`timescale 1ns / 1ps
`include "api_frame_receive_router_unit_macros.svh"

module afrr_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  afrr_pkg::cfg_t    cfg,
	input  logic              in_accept,
	input  logic [7:0]        in_byte,
	output afrr_pkg::result_t res
);
	import afrr_pkg::*;

	logic [POS_W-1:0] pos_q, pos_d, pos_inc, data_idx;
	logic [15:0]      len_q, len_d;
	logic [7:0]       kind_q, kind_d;
	logic [7:0]       stat_q, stat_d;

	always_comb begin
		res      = '0;
		pos_d    = pos_q;
		len_d    = len_q;
		kind_d   = kind_q;
		stat_d   = stat_q;
		pos_inc  = pos_q + 17'd1;
		data_idx = pos_inc - DATA_OFFSET;
		if (cfg.enable) begin
			if (pos_q == '0) begin
				if (in_byte == START_BYTE) begin
					pos_d = 17'd1;
					len_d = '0;
				end
			end else begin
				pos_d = pos_inc;
				if (pos_inc == POS_LEN_HI) begin
					len_d = len_q + {in_byte, 8'h00};
				end else if (pos_inc == POS_LEN_LO) begin
					len_d = len_q + {8'h00, in_byte};
				end else if (pos_inc == POS_KIND) begin
					kind_d = in_byte;
				end else if (data_idx < {1'b0, len_q}) begin
					case (kind_q)
						KIND_AT_RESP: begin
							if (pos_inc == POS_AT_STATUS) begin
								stat_d = in_byte;
							end else if (pos_inc > POS_AT_STATUS) begin
								res.at_byte_valid = 1'b1;
								res.byte_value    = in_byte;
							end
							// The status byte may itself be the last data byte.
							if (data_idx + 17'd1 == {1'b0, len_q}) begin
								res.at_done   = 1'b1;
								res.at_result = stat_d;
							end
						end
						KIND_MODEM: begin
							if (pos_inc == POS_MODEM && in_byte != cfg.join_open_code &&
							    in_byte != cfg.join_closed_code) begin
								res.status_valid = 1'b1;
								res.modem_code   = in_byte;
							end
						end
						KIND_RX_PACKET: begin
							if (pos_inc >= POS_PAYLOAD) begin
								res.payload_valid = 1'b1;
								res.byte_value    = in_byte;
							end
						end
						default: begin
						end
					endcase
				end else begin
					res.frame_end = 1'b1;
					pos_d         = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			len_q  <= '0;
			kind_q <= '0;
			stat_q <= '0;
		end else if (in_accept) begin
			pos_q  <= pos_d;
			len_q  <= len_d;
			kind_q <= kind_d;
			stat_q <= stat_d;
		end
	end

	`AFRR_ASSERT_NOW(a_disabled_quiet, in_accept && !cfg.enable, res == '0,
		"disabled parser produced a non-zero result")
	`AFRR_ASSERT_NOW(a_one_byte_route, in_accept, !(res.at_byte_valid && res.payload_valid),
		"byte routed to both queues")
	`AFRR_ASSERT_NEXT(a_end_rehunt, in_accept && res.frame_end, pos_q == '0,
		"frame end did not return to hunting")
	`AFRR_ASSERT_NEXT(a_hunt_hold, in_accept && pos_q == '0 && in_byte != START_BYTE,
		pos_q == '0, "left hunting without a start byte")

endmodule

>>> hw/rtl/afrr_out_buf.sv
// Two-entry output buffer: result register plus skid register.
`timescale 1ns / 1ps
`include "api_frame_receive_router_unit_macros.svh"

module afrr_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  afrr_pkg::result_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output afrr_pkg::result_t out_data
);
	import afrr_pkg::*;

	logic    out_valid_q, skid_valid_q;
	result_t out_q, skid_q;
	logic    push, load_out;

	assign in_ready  = !skid_valid_q;
	assign push      = in_valid && in_ready;
	assign load_out  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load_out) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= in_data;
			end
		end else if (push) begin
			skid_q <= in_data;
		end
	end

	`AFRR_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q,
		"skid entry held while result register empty")
	`AFRR_ASSERT_NEXT(a_stall_to_skid, out_valid_q && !out_ready && push, skid_valid_q,
		"stalled beat not captured in skid register")
	`AFRR_ASSERT_NEXT(a_skid_drain, skid_valid_q && out_ready, out_valid_q && !skid_valid_q,
		"skid entry not moved to result register")

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the frame receive router: stream driver, result monitor, predictor.
`timescale 1ns / 1ps

module testbench;
	import afrr_pkg::*;

	// The run is stopped as failed if it ever gets this far. A correct run of a few hundred
	// bytes ends well before this limit, even under the longest stalls.
	localparam int CYCLE_LIMIT = 100000;
	// Length of the one long receiver hold-off that backs the block up into its input.
	localparam int HOLD_CYCLES = 80;
	// Pause after the last expected result.
	localparam int SETTLE_CYCLES = 4;
	// Directed bytes, sent in source order (leftmost first).
	localparam int DIRECTED_LEN = 25;
	localparam logic [DIRECTED_LEN*8-1:0] DIRECTED_BYTES = {
		// Bytes that are not a start byte while hunting, at both extremes.
		8'h00, 8'hFF,
		// Zero length with an unknown type: the next byte is taken as the checksum.
		START_BYTE, 8'h00, 8'h00, 8'hFF, 8'h5A,
		// AT response too short to carry a status byte: completion reports the old status.
		START_BYTE, 8'h00, 8'h02, KIND_AT_RESP, 8'h55, 8'hC3,
		// Modem status equal to the join-open code, which is filtered out.
		START_BYTE, 8'h00, 8'h02, KIND_MODEM, JOIN_OPEN_RESET, 8'h11,
		// Modem status that is itself a start byte: it is plain data inside a frame.
		START_BYTE, 8'h00, 8'h02, KIND_MODEM, START_BYTE, 8'h22
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Byte stream into the block.
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'h00;    // [7:0] rx_byte

	// Result stream out of the block.
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;           // [7:0] byte_value, [15:8] modem_code, [23:16] at_result
	logic [3:0] m_tuser;            // [0] at_byte_valid, [1] payload_valid, [2] status_valid,
	                                // [3] at_done
	logic m_tlast;                  // frame_end

	// Register write port.
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	api_frame_receive_router_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Bytes waiting to be offered, and routing results still owed by the block.
	logic [7:0] rx_stream[$];
	result_t expected_routes[$];

	int unsigned bytes_queued = 0;
	int unsigned bytes_accepted = 0;
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;

	// Traffic shaping. gaps_on lets both sides idle at random; hold_req asks the receiver
	// for its one long hold-off.
	bit gaps_on = 1'b1;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int unsigned hold_count = 0;
	bit byte_taken = 1'b0;

	// Our own copy of the register file, tracking each write as it is issued.
	logic cfg_enable = 1'b0;
	logic [7:0] join_open = JOIN_OPEN_RESET;
	logic [7:0] join_closed = JOIN_CLOSED_RESET;

	// Parser state of the predictor. rx_pos is zero while hunting for a start byte,
	// otherwise the position of the last byte taken, with the start byte at one.
	logic [POS_W-1:0] rx_pos = '0;
	logic [15:0] rx_len = '0;
	logic [7:0] rx_kind = '0;
	logic [7:0] at_status_latch = '0;

	// Works out the result of one received byte and advances the parser state.
	function automatic result_t route_byte(input logic [7:0] b);
		result_t r;
		logic [POS_W-1:0] pos;
		r = '0;
		if (cfg_enable) begin
			if (rx_pos == '0) begin
				if (b == START_BYTE) begin
					rx_pos = POS_W'(1);
					rx_len = '0;
				end
			end else begin
				pos = rx_pos + 1'b1;
				rx_pos = pos;
				if (pos == POS_LEN_HI) begin
					rx_len = rx_len + {b, 8'h00};
				end else if (pos == POS_LEN_LO) begin
					rx_len = rx_len + {8'h00, b};
				end else if (pos == POS_KIND) begin
					rx_kind = b;
				end else if (pos - DATA_OFFSET < {1'b0, rx_len}) begin
					// Data byte. The length counts the type byte, so there are
					// rx_len - 1 of these.
					case (rx_kind)
						KIND_AT_RESP: begin
							if (pos == POS_AT_STATUS) begin
								at_status_latch = b;
							end else if (pos > POS_AT_STATUS) begin
								r.at_byte_valid = 1'b1;
								r.byte_value = b;
							end
							// The last data byte completes the response, with
							// whatever status is latched by then.
							if (pos - DATA_OFFSET == {1'b0, rx_len} - 1'b1) begin
								r.at_done = 1'b1;
								r.at_result = at_status_latch;
							end
						end
						KIND_MODEM: begin
							if (pos == POS_MODEM && b != join_open && b != join_closed) begin
								r.status_valid = 1'b1;
								r.modem_code = b;
							end
						end
						KIND_RX_PACKET: begin
							if (pos >= POS_PAYLOAD) begin
								r.payload_valid = 1'b1;
								r.byte_value = b;
							end
						end
						default: begin
						end
					endcase
				end else begin
					// Checksum: not verified, it just closes the frame.
					r.frame_end = 1'b1;
					rx_pos = '0;
				end
			end
		end
		return r;
	endfunction

	// One line per mismatch; the printing stops after a hundred so that a badly broken
	// block cannot flood the log, but every mismatch is counted.
	task automatic report_mismatch(input string msg);
		if (error_count < 100)
			$display("MISMATCH at %0t ns: %s", $time, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%02h, expected 0x%02h", name, got, want));
	endtask

	task automatic check_flag(input string name, input logic got, input logic want);
		if (got !== want)
			report_mismatch($sformatf("%s got %b, expected %b", name, got, want));
	endtask

	// Sender side. A beat that has been offered stays on the bus until it is taken;
	// only then, or from idle, is the next byte considered.
	always @(negedge clk) begin
		if (!s_tvalid || byte_taken) begin
			if (rx_stream.size() != 0 && (!gaps_on || $urandom_range(99) >= 35)) begin
				s_tdata <= rx_stream.pop_front();
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver side. The long hold-off is counted here, independently of the sender,
	// so the block's small output buffer fills and s_tready has to drop.
	always @(negedge clk) begin
		if (hold_req && !hold_done) begin
			m_tready <= 1'b0;
			hold_count <= hold_count + 1;
			if (hold_count == HOLD_CYCLES - 1)
				hold_done <= 1'b1;
		end else if (gaps_on) begin
			m_tready <= ($urandom_range(99) >= 35);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Monitor. Result beats are checked before the byte taken at the same edge is
	// predicted, so a result can never be matched against the expectation of that byte.
	always @(posedge clk) begin : monitor
		result_t want;
		byte_taken <= s_tvalid && s_tready;
		if (arst_n) begin
			if (m_tvalid === 1'b1 && m_tready) begin
				if (expected_routes.size() == 0) begin
					report_mismatch("result beat with no byte outstanding");
				end else begin
					want = expected_routes.pop_front();
					check_flag("at_byte_valid", m_tuser[0], want.at_byte_valid);
					check_flag("payload_valid", m_tuser[1], want.payload_valid);
					check_flag("status_valid", m_tuser[2], want.status_valid);
					check_flag("at_done", m_tuser[3], want.at_done);
					check_field("byte_value", m_tdata[7:0], want.byte_value);
					check_field("modem_code", m_tdata[15:8], want.modem_code);
					check_field("at_result", m_tdata[23:16], want.at_result);
					check_flag("frame_end", m_tlast, want.frame_end);
				end
			end
			if (s_tvalid && s_tready === 1'b1) begin
				expected_routes.push_back(route_byte(s_tdata));
				bytes_accepted++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[api_frame_receive_router_unit] ERROR");
			$finish;
		end
	end

	task automatic push_byte(input logic [7:0] b);
		rx_stream.push_back(b);
		bytes_queued++;
	endtask

	// Registers change only with nothing in flight. The write is held for one edge, and
	// the byte stream resumes only after the write has landed.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		case (idx)
			REG_ENABLE: cfg_enable = value[0];
			REG_JOIN_OPEN: join_open = value;
			REG_JOIN_CLOSED: join_closed = value;
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// Wait until every queued byte has been taken and every result has come back.
	task automatic drain_results();
		while (bytes_accepted != bytes_queued || expected_routes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Modem codes lean on the two filtered values and the start byte.
	function automatic logic [7:0] pick_modem_code();
		case ($urandom_range(3))
			0: return join_open;
			1: return join_closed;
			2: return START_BYTE;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// A well-formed frame: start, big-endian length, type, length - 1 data bytes, checksum.
	task automatic queue_frame(input logic [7:0] kind, input int unsigned len);
		logic [15:0] flen;
		flen = 16'(len);
		push_byte(START_BYTE);
		push_byte(flen[15:8]);
		push_byte(flen[7:0]);
		push_byte(kind);
		for (int unsigned i = 1; i < len; i++) begin
			if (kind == KIND_MODEM && i == 1)
				push_byte(pick_modem_code());
			else
				push_byte(8'($urandom_range(255)));
		end
		push_byte(8'($urandom_range(255)));
	endtask

	// Mostly well-formed frames with random content and lengths; the rest is line noise
	// and frames cut short, which throw the parser out of step until a checksum lands.
	task automatic random_traffic(input int unsigned count);
		int unsigned start_count;
		int unsigned len;
		int unsigned roll;
		logic [7:0] kind;
		logic [7:0] b;
		start_count = bytes_queued;
		while (bytes_queued - start_count < count) begin
			roll = $urandom_range(99);
			if (roll < 75) begin
				case ($urandom_range(6))
					0, 1: kind = KIND_AT_RESP;
					2, 3: kind = KIND_MODEM;
					4, 5: kind = KIND_RX_PACKET;
					default: kind = 8'($urandom_range(255));
				endcase
				case ($urandom_range(19))
					0: len = $urandom_range(300, 256);
					1, 2, 3, 4: len = $urandom_range(40, 13);
					default: len = $urandom_range(14, 0);
				endcase
				queue_frame(kind, len);
			end else if (roll < 90) begin
				repeat ($urandom_range(4, 1)) begin
					b = 8'($urandom_range(255));
					push_byte(b == START_BYTE ? ~b : b);
				end
			end else begin
				push_byte(START_BYTE);
				repeat ($urandom_range(3, 1)) push_byte(8'($urandom_range(255)));
			end
		end
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// The parser comes out of reset disabled: these bytes must be dropped.
		push_byte(START_BYTE);
		push_byte(8'h00);
		drain_results();

		write_reg(REG_ENABLE, 8'h01);
		for (int i = DIRECTED_LEN - 1; i >= 0; i--)
			push_byte(DIRECTED_BYTES[8*i +: 8]);
		drain_results();

		// Extreme filter codes, with the receiver's long hold-off at the start.
		write_reg(REG_JOIN_OPEN, 8'h00);
		write_reg(REG_JOIN_CLOSED, 8'hFF);
		hold_req = 1'b1;
		random_traffic(100);
		drain_results();

		// Codes swapped, and a stretch where neither side ever idles.
		write_reg(REG_JOIN_OPEN, 8'hFF);
		write_reg(REG_JOIN_CLOSED, 8'h00);
		gaps_on = 1'b0;
		random_traffic(100);
		drain_results();
		gaps_on = 1'b1;

		// Both filters on the same random code.
		write_reg(REG_JOIN_OPEN, 8'($urandom_range(255)));
		write_reg(REG_JOIN_CLOSED, join_open);
		random_traffic(100);
		drain_results();

		// Disable, likely in the middle of a frame: the state must hold across the
		// ignored bytes and parsing picks up where it stopped.
		write_reg(REG_ENABLE, 8'h00);
		push_byte(START_BYTE);
		repeat (7) push_byte(8'($urandom_range(255)));
		drain_results();
		write_reg(REG_ENABLE, 8'h01);
		write_reg(REG_JOIN_OPEN, JOIN_OPEN_RESET);
		write_reg(REG_JOIN_CLOSED, JOIN_CLOSED_RESET);
		random_traffic(100);
		drain_results();

		if (error_count == 0)
			$display("[api_frame_receive_router_unit] OK");
		else
			$display("[api_frame_receive_router_unit] ERROR");
		$finish;
	end

endmodule

>>> api_frame_receive_router_unit.f
+incdir+hw/rtl
hw/rtl/afrr_pkg.sv
hw/rtl/afrr_parser.sv
hw/rtl/afrr_out_buf.sv
hw/rtl/api_frame_receive_router_unit.sv
verif/testbench.sv
